// ----- hw/rtl/bssc_pkg.sv -----
// shared types, register map and commutation tables for the six-step commutator
package bssc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_DIRECTION_FORWARD = 3'd0;
    localparam logic [2:0] REG_MANUAL_MODE       = 3'd1;
    localparam logic [2:0] REG_SINGLE_STEP       = 3'd2;
    localparam logic [2:0] REG_START_TARGET      = 3'd3;
    localparam logic [2:0] REG_STOP_PERIOD       = 3'd4;
    localparam logic [2:0] REG_ON_BEFORE_SAMPLE  = 3'd5;
    localparam logic [2:0] REG_ON_SAMPLE         = 3'd6;
    localparam logic [2:0] REG_OFF_TIME          = 3'd7;

    // event kinds
    localparam logic KIND_COMMUTATE = 1'b0;
    localparam logic KIND_PWM       = 1'b1;

    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd6;

    // phase bits for gate words
    localparam logic [2:0] PH_A = 3'b001;
    localparam logic [2:0] PH_B = 3'b010;
    localparam logic [2:0] PH_C = 3'b100;

    // floating phase codes
    localparam logic [1:0] FLOAT_A = 2'd0;
    localparam logic [1:0] FLOAT_B = 2'd1;
    localparam logic [1:0] FLOAT_C = 2'd2;

    typedef enum logic [1:0] {
        PWM_OFF    = 2'd0,
        PWM_ON_PRE = 2'd1,
        PWM_ON_ADC = 2'd2
    } pwm_state_t;

    typedef enum logic [1:0] {
        AUTO_STARTING = 2'd0,
        AUTO_RUNNING  = 2'd1,
        AUTO_STOPPING = 2'd2
    } auto_state_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] step_period;
        logic        request_stop;
    } item_t;

    typedef struct packed {
        logic [2:0]  gate_high;
        logic [2:0]  gate_low;
        logic [1:0]  float_phase;
        logic [2:0]  step_now;
        logic [1:0]  pwm_phase;
        logic [15:0] pwm_reload;
        logic [15:0] new_period;
        logic        stop_flag;
        logic        detect_zero_cross;
        logic [1:0]  run_phase;
        logic [15:0] step_total;
    } result_t;

    // configuration seen by the core
    typedef struct packed {
        logic        direction_forward;
        logic        manual_mode;
        logic        single_step;
        logic [15:0] start_target_period;
        logic [15:0] stop_period;
        logic [15:0] on_before_sample_time;
        logic [15:0] on_sample_time;
        logic [15:0] off_time;
    } cfg_t;

    function automatic logic [2:0] pair_high(input logic [2:0] step);
        logic [2:0] g;
        case (step)
            3'd1, 3'd2: g = PH_A;
            3'd3, 3'd4: g = PH_B;
            3'd5, 3'd6: g = PH_C;
            default:    g = 3'b000;
        endcase
        return g;
    endfunction

    function automatic logic [2:0] pair_low(input logic [2:0] step);
        logic [2:0] g;
        case (step)
            3'd1, 3'd6: g = PH_B;
            3'd2, 3'd3: g = PH_C;
            3'd4, 3'd5: g = PH_A;
            default:    g = 3'b000;
        endcase
        return g;
    endfunction

    function automatic logic [1:0] float_of(input logic [2:0] step);
        logic [1:0] f;
        case (step)
            3'd1, 3'd4: f = FLOAT_C;
            3'd2, 3'd5: f = FLOAT_B;
            default:    f = FLOAT_A;
        endcase
        return f;
    endfunction

endpackage

// ----- hw/rtl/bssc_regs.sv -----
// apb configuration register file for the six-step commutator
module bssc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bssc_pkg::ADDR_W-1:0] paddr,
    input  logic [bssc_pkg::DATA_W-1:0] pwdata,
    output logic [bssc_pkg::DATA_W-1:0] prdata,
    input  logic                        clear_single,
    output bssc_pkg::cfg_t              cfg
);
    import bssc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        // one-shot clears itself after the step it stops
        if (clear_single)
        begin
            cfg_next.single_step = 1'b0;
        end
        if (wr_en)
        begin
            case (idx)
                REG_DIRECTION_FORWARD: cfg_next.direction_forward     = pwdata[0];
                REG_MANUAL_MODE:       cfg_next.manual_mode           = pwdata[0];
                REG_SINGLE_STEP:       cfg_next.single_step           = pwdata[0];
                REG_START_TARGET:      cfg_next.start_target_period   = pwdata[15:0];
                REG_STOP_PERIOD:       cfg_next.stop_period           = pwdata[15:0];
                REG_ON_BEFORE_SAMPLE:  cfg_next.on_before_sample_time = pwdata[15:0];
                REG_ON_SAMPLE:         cfg_next.on_sample_time        = pwdata[15:0];
                REG_OFF_TIME:          cfg_next.off_time              = pwdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction_forward     <= 1'b1;
            cfg_reg.manual_mode           <= 1'b1;
            cfg_reg.single_step           <= 1'b0;
            cfg_reg.start_target_period   <= 16'd0;
            cfg_reg.stop_period           <= 16'hFFFF;
            cfg_reg.on_before_sample_time <= 16'd0;
            cfg_reg.on_sample_time        <= 16'd0;
            cfg_reg.off_time              <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_DIRECTION_FORWARD: prdata = {31'd0, cfg_reg.direction_forward};
            REG_MANUAL_MODE:       prdata = {31'd0, cfg_reg.manual_mode};
            REG_SINGLE_STEP:       prdata = {31'd0, cfg_reg.single_step};
            REG_START_TARGET:      prdata = {16'd0, cfg_reg.start_target_period};
            REG_STOP_PERIOD:       prdata = {16'd0, cfg_reg.stop_period};
            REG_ON_BEFORE_SAMPLE:  prdata = {16'd0, cfg_reg.on_before_sample_time};
            REG_ON_SAMPLE:         prdata = {16'd0, cfg_reg.on_sample_time};
            REG_OFF_TIME:          prdata = {16'd0, cfg_reg.off_time};
            default:               prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

    // a one-shot clear with no write leaves the bit low
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_single && !wr_en |=> !cfg_reg.single_step)
        else $error("single step not cleared");

endmodule

// ----- hw/rtl/bssc_core.sv -----
// commutation state and one-pass next-state / result logic
module bssc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bssc_pkg::item_t   item,
    input  bssc_pkg::cfg_t    cfg,
    output logic              clear_single,
    output bssc_pkg::result_t result
);
    import bssc_pkg::*;

    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    pwm_state_t  pwm_reg;
    pwm_state_t  pwm_next;
    auto_state_t auto_reg;
    auto_state_t auto_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] reload;
    logic [15:0] period;
    logic        stop;
    logic        pwm_on;

    always_comb
    begin
        step_next    = step_reg;
        pwm_next     = pwm_reg;
        auto_next    = auto_reg;
        count_next   = count_reg;
        reload       = 16'd0;
        period       = item.step_period;
        stop         = 1'b0;
        clear_single = 1'b0;

        if (item.kind == KIND_COMMUTATE)
        begin
            if (cfg.direction_forward)
            begin
                step_next = (step_reg >= STEP_LAST) ? STEP_FIRST : step_reg + 3'd1;
            end
            else
            begin
                step_next = (step_reg <= STEP_FIRST) ? STEP_LAST : step_reg - 3'd1;
            end

            if (cfg.manual_mode)
            begin
                if (cfg.single_step)
                begin
                    stop         = 1'b1;
                    clear_single = accept;
                end
            end
            else
            begin
                // stop request takes effect before the state check
                if (item.request_stop)
                begin
                    auto_next = AUTO_STOPPING;
                end
                if (auto_next == AUTO_STARTING)
                begin
                    if (item.step_period < cfg.start_target_period)
                    begin
                        auto_next = AUTO_RUNNING;
                        period    = {1'b0, item.step_period[15:1]};
                    end
                end
                else if (auto_next == AUTO_STOPPING)
                begin
                    stop = (item.step_period > cfg.stop_period);
                end
            end
            count_next = count_reg + 16'd1;
        end
        else
        begin
            case (pwm_reg)
                PWM_OFF:
                begin
                    pwm_next = PWM_ON_PRE;
                    reload   = cfg.on_before_sample_time;
                end
                PWM_ON_PRE:
                begin
                    pwm_next = PWM_ON_ADC;
                    reload   = cfg.on_sample_time;
                end
                default:
                begin
                    pwm_next = PWM_OFF;
                    reload   = cfg.off_time;
                end
            endcase
        end
    end

    always_comb
    begin
        pwm_on                   = (pwm_next != PWM_OFF);
        result.gate_high         = pwm_on ? pair_high(step_next) : 3'b000;
        result.gate_low          = pwm_on ? pair_low(step_next) : 3'b000;
        result.float_phase       = float_of(step_next);
        result.step_now          = step_next;
        result.pwm_phase         = pwm_next;
        result.pwm_reload        = reload;
        result.new_period        = period;
        result.stop_flag         = stop;
        result.detect_zero_cross = !cfg.manual_mode && (auto_next == AUTO_RUNNING);
        result.run_phase         = auto_next;
        result.step_total        = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_FIRST;
            pwm_reg   <= PWM_OFF;
            auto_reg  <= AUTO_STARTING;
            count_reg <= 16'd0;
        end
        else if (accept)
        begin
            step_reg  <= step_next;
            pwm_reg   <= pwm_next;
            auto_reg  <= auto_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg >= STEP_FIRST && step_reg <= STEP_LAST)
        else $error("step left the 1..6 ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.kind == KIND_COMMUTATE |=> step_reg != $past(step_reg))
        else $error("commutation did not move the step");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.kind == KIND_COMMUTATE |=> $stable(pwm_reg))
        else $error("pwm state moved on a commutation word");

endmodule

// ----- hw/rtl/bldc_six_step_commutator.sv -----
// top level of the six-step bldc commutator: handshake, output register, config port
// The commutator takes one event word per clock on the item channel unless it stalls and
// returns exactly one result word for each, in the next cycle, from a single output
// register. All next-state and result logic (step ring, pwm phase cycle, start/run/stop
// sequencing and the gate tables) sits in one short combinational pass between the
// accepted item and that register, so the sustained rate is one word per cycle while
// the result channel does not stall. The item channel stalls only while a finished
// result is held and the result channel is stalled; a result taken in the same cycle
// frees the register for the next word. Configuration goes through the apb port
// (register i at byte address 4*i) and should be written only while no word is in
// flight. The single_step bit clears itself after the commutation it stops.
module bldc_six_step_commutator (
    input  logic                        clk,
    input  logic                        rst_n,
    // event words
    input  logic                        item_valid,
    output logic                        item_stall,
    input  bssc_pkg::item_t             item,
    // result words
    output logic                        result_valid,
    input  logic                        result_stall,
    output bssc_pkg::result_t           result,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bssc_pkg::ADDR_W-1:0] paddr,
    input  logic [bssc_pkg::DATA_W-1:0] pwdata,
    output logic [bssc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import bssc_pkg::*;

    cfg_t    cfg;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    accept;
    logic    clear_single;

    // zero wait-state port
    assign pready = 1'b1;

    bssc_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .clear_single (clear_single),
        .cfg          (cfg)
    );

    // hold off new words only while a result waits and the sink is stalled
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    bssc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .cfg          (cfg),
        .clear_single (clear_single),
        .result       (core_result)
    );

    // result payload, loaded on every accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= core_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // every accepted word shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted word produced no result");

    // input side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid_reg && result_stall)
        else $error("item stalled with output register free");

endmodule

// ----- dv/bldc_six_step_commutator_checker.sv -----
// checker for the six-step commutator: predicts each result word and compares it field by field
module bldc_six_step_commutator_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_stall,
    input  bssc_pkg::item_t             item,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  bssc_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [bssc_pkg::ADDR_W-1:0] paddr,
    input  logic [bssc_pkg::DATA_W-1:0] pwdata,
    output int                          pending,
    output int                          fail_count
);
    import bssc_pkg::*;

    // shadow of the register file and of the commutator state
    cfg_t        regs;
    logic [2:0]  step_q;
    pwm_state_t  pwm_q;
    auto_state_t run_q;
    logic [15:0] total_q;

    result_t expected_words[$];

    task automatic note_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result field %0s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // advances the shadow state by one event word and returns the word it should produce
    function automatic result_t commutate(input item_t w);
        result_t     r;
        logic [15:0] period;
        logic [15:0] reload;
        logic        stop;
        logic [2:0]  hi;
        logic [2:0]  lo;
        logic [1:0]  fl;
        period = w.step_period;
        reload = 16'd0;
        stop   = 1'b0;
        if (w.kind == KIND_COMMUTATE)
        begin
            if (regs.direction_forward)
                step_q = (step_q >= STEP_LAST) ? STEP_FIRST : step_q + 3'd1;
            else
                step_q = (step_q <= STEP_FIRST) ? STEP_LAST : step_q - 3'd1;
            if (regs.manual_mode)
            begin
                if (regs.single_step)
                begin
                    stop = 1'b1;
                    regs.single_step = 1'b0;
                end
            end
            else
            begin
                if (w.request_stop)
                    run_q = AUTO_STOPPING;
                if (run_q == AUTO_STARTING)
                begin
                    if (period < regs.start_target_period)
                    begin
                        run_q  = AUTO_RUNNING;
                        period = period >> 1;
                    end
                end
                else if (run_q == AUTO_STOPPING)
                begin
                    if (period > regs.stop_period)
                        stop = 1'b1;
                end
            end
            total_q = total_q + 16'd1;
        end
        else
        begin
            case (pwm_q)
                PWM_OFF:
                begin
                    pwm_q  = PWM_ON_PRE;
                    reload = regs.on_before_sample_time;
                end
                PWM_ON_PRE:
                begin
                    pwm_q  = PWM_ON_ADC;
                    reload = regs.on_sample_time;
                end
                default:
                begin
                    pwm_q  = PWM_OFF;
                    reload = regs.off_time;
                end
            endcase
        end
        // driven pair and floating phase of each step
        case (step_q)
            3'd1:    {hi, lo, fl} = {PH_A, PH_B, FLOAT_C};
            3'd2:    {hi, lo, fl} = {PH_A, PH_C, FLOAT_B};
            3'd3:    {hi, lo, fl} = {PH_B, PH_C, FLOAT_A};
            3'd4:    {hi, lo, fl} = {PH_B, PH_A, FLOAT_C};
            3'd5:    {hi, lo, fl} = {PH_C, PH_A, FLOAT_B};
            default: {hi, lo, fl} = {PH_C, PH_B, FLOAT_A};
        endcase
        r.gate_high         = (pwm_q != PWM_OFF) ? hi : 3'b000;
        r.gate_low          = (pwm_q != PWM_OFF) ? lo : 3'b000;
        r.float_phase       = fl;
        r.step_now          = step_q;
        r.pwm_phase         = pwm_q;
        r.pwm_reload        = reload;
        r.new_period        = period;
        r.stop_flag         = stop;
        r.detect_zero_cross = !regs.manual_mode && (run_q == AUTO_RUNNING);
        r.run_phase         = run_q;
        r.step_total        = total_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            regs.direction_forward     = 1'b1;
            regs.manual_mode           = 1'b1;
            regs.single_step           = 1'b0;
            regs.start_target_period   = 16'h0000;
            regs.stop_period           = 16'hFFFF;
            regs.on_before_sample_time = 16'h0000;
            regs.on_sample_time        = 16'h0000;
            regs.off_time              = 16'h0000;
            step_q     = STEP_FIRST;
            pwm_q      = PWM_OFF;
            run_q      = AUTO_STARTING;
            total_q    = 16'd0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_DIRECTION_FORWARD: regs.direction_forward     = pwdata[0];
                    REG_MANUAL_MODE:       regs.manual_mode           = pwdata[0];
                    REG_SINGLE_STEP:       regs.single_step           = pwdata[0];
                    REG_START_TARGET:      regs.start_target_period   = pwdata[15:0];
                    REG_STOP_PERIOD:       regs.stop_period           = pwdata[15:0];
                    REG_ON_BEFORE_SAMPLE:  regs.on_before_sample_time = pwdata[15:0];
                    REG_ON_SAMPLE:         regs.on_sample_time        = pwdata[15:0];
                    default:               regs.off_time              = pwdata[15:0];
                endcase
            end
            // compare before queuing so a word taken this edge never meets its own expectation
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result word with nothing expected: %0h", result);
                end
                else
                begin
                    want = expected_words.pop_front();
                    note_field("gate_high", 16'(want.gate_high), 16'(result.gate_high));
                    note_field("gate_low", 16'(want.gate_low), 16'(result.gate_low));
                    note_field("float_phase", 16'(want.float_phase),
                               16'(result.float_phase));
                    note_field("step_now", 16'(want.step_now), 16'(result.step_now));
                    note_field("pwm_phase", 16'(want.pwm_phase), 16'(result.pwm_phase));
                    note_field("pwm_reload", want.pwm_reload, result.pwm_reload);
                    note_field("new_period", want.new_period, result.new_period);
                    note_field("stop_flag", 16'(want.stop_flag), 16'(result.stop_flag));
                    note_field("detect_zero_cross", 16'(want.detect_zero_cross),
                               16'(result.detect_zero_cross));
                    note_field("run_phase", 16'(want.run_phase), 16'(result.run_phase));
                    note_field("step_total", want.step_total, result.step_total);
                end
            end
            if (item_valid && !item_stall)
                expected_words.push_back(commutate(item));
        end
        pending = expected_words.size();
    end

endmodule

// ----- dv/bldc_six_step_commutator_tb.sv -----
// stimulus, clock, reset and verdict for the six-step commutator
module bldc_six_step_commutator_tb;
    import bssc_pkg::*;

    // longest stretch without any word moving before the run is called hung
    localparam int QUIET_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int pending;
    int fail_count;

    // chance in percent that the sender skips a cycle / the receiver stalls
    int tx_idle_pct;
    int rx_idle_pct;
    int quiet_cycles;
    logic dir_now;

    bldc_six_step_commutator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    bldc_six_step_commutator_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // watchdog: ends the run when neither channel has moved a word for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bldc_six_step_commutator: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic item_t event_word(input logic kind, input logic [15:0] period,
                                         input logic req);
        item_t w;
        w.kind         = kind;
        w.step_period  = period;
        w.request_stop = req;
        return w;
    endfunction

    // random event word; periods cluster at the floor, the top and at or just above a pivot
    function automatic item_t random_word(input int req_pct, input logic [15:0] floor,
                                          input logic [15:0] pivot);
        item_t w;
        w.kind         = ($urandom_range(99) < 45) ? KIND_COMMUTATE : KIND_PWM;
        w.request_stop = ($urandom_range(99) < req_pct);
        case ($urandom_range(7))
            0:       w.step_period = floor;
            1:       w.step_period = 16'hFFFF;
            2, 3:    w.step_period = 16'($urandom_range(32'(pivot) + 2, 32'(pivot)));
            default: w.step_period = 16'($urandom_range(32'hFFFF, 32'(floor)));
        endcase
        return w;
    endfunction

    // offers one word, with random idle cycles ahead of it, and returns at the edge
    // that takes it; valid stays high so back-to-back words need no extra cycle
    task automatic send_word(input item_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, then psel returns low before the task ends
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic dir, input logic manual, input logic single,
                                input logic [15:0] target, input logic [15:0] stop_at,
                                input logic [15:0] on_pre, input logic [15:0] on_adc,
                                input logic [15:0] off_len);
        dir_now = dir;
        write_reg(REG_DIRECTION_FORWARD, {15'd0, dir});
        write_reg(REG_MANUAL_MODE, {15'd0, manual});
        write_reg(REG_SINGLE_STEP, {15'd0, single});
        write_reg(REG_START_TARGET, target);
        write_reg(REG_STOP_PERIOD, stop_at);
        write_reg(REG_ON_BEFORE_SAMPLE, on_pre);
        write_reg(REG_ON_SAMPLE, on_adc);
        write_reg(REG_OFF_TIME, off_len);
    endtask

    // random words; half way the sender holds off until the block is empty, then the
    // direction is flipped and single-step armed again
    task automatic run_random(input int count, input int req_pct, input logic [15:0] floor,
                              input logic [15:0] pivot);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                drain();
                dir_now = ~dir_now;
                write_reg(REG_DIRECTION_FORWARD, {15'd0, dir_now});
                write_reg(REG_SINGLE_STEP, 16'd1);
            end
            send_word(random_word(req_pct, floor, pivot));
        end
        drain();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        tx_idle_pct  = 32;
        rx_idle_pct  = 45;
        dir_now      = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: manual, forward; pwm on, then a full turn of the step ring
        send_word(event_word(KIND_PWM, 16'h0000, 1'b0));
        // stop request in manual mode is ignored
        send_word(event_word(KIND_COMMUTATE, 16'hFFFF, 1'b1));
        send_word(event_word(KIND_COMMUTATE, 16'h0000, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'h1234, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'h8000, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'h7FFF, 1'b0));
        // step 6 wraps back to step 1
        send_word(event_word(KIND_COMMUTATE, 16'h0001, 1'b0));
        send_word(event_word(KIND_PWM, 16'hFFFF, 1'b1));
        // back to off: gates drop
        send_word(event_word(KIND_PWM, 16'h5555, 1'b0));
        drain();

        // backward, single-step, extreme reload times
        program_regs(1'b0, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hA5A5, 16'h5A5A);
        // step 1 wraps to step 6 and single-step raises stop once, then clears
        send_word(event_word(KIND_COMMUTATE, 16'hFFFF, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'hFFFF, 1'b0));
        send_word(event_word(KIND_PWM, 16'h0000, 1'b0));
        send_word(event_word(KIND_PWM, 16'h0000, 1'b0));
        send_word(event_word(KIND_PWM, 16'h0000, 1'b0));
        drain();

        // random manual stepping, stop requests ignored
        program_regs(1'b1, 1'b1, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        run_random(110, 50, 16'h0000, 16'h0000);

        // automatic, still starting: periods never fall below the target
        program_regs(1'b0, 1'b0, 1'b0, 16'h0010, 16'hFFFF, 16'($urandom), 16'($urandom),
                     16'($urandom));
        run_random(100, 0, 16'h0010, 16'h0010);

        // starting to running right at the target boundary
        program_regs(1'b1, 1'b0, 1'b0, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001);
        send_word(event_word(KIND_COMMUTATE, 16'hFFFF, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'h8000, 1'b0));
        send_word(event_word(KIND_PWM, 16'h0000, 1'b0));
        // just below target: running, and the period is halved
        send_word(event_word(KIND_COMMUTATE, 16'h7FFF, 1'b0));
        // zero-cross detection armed on any event while running
        send_word(event_word(KIND_PWM, 16'h0000, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'h0000, 1'b0));
        drain();

        // running, random traffic, idling the other way round
        tx_idle_pct = 45;
        rx_idle_pct = 32;
        program_regs(1'b0, 1'b0, 1'b0, 16'h0000, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        run_random(100, 0, 16'h0000, 16'h4000);

        // stopping, no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'h8000, 16'($urandom), 16'($urandom),
                     16'($urandom));
        // request enters stopping first, so the stop check applies on the same word
        send_word(event_word(KIND_COMMUTATE, 16'hFFFF, 1'b1));
        send_word(event_word(KIND_COMMUTATE, 16'h8000, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'h8001, 1'b0));
        run_random(60, 10, 16'h0000, 16'h8000);

        // lowest stop period: any nonzero period stops
        write_reg(REG_STOP_PERIOD, 16'h0000);
        send_word(event_word(KIND_COMMUTATE, 16'h0000, 1'b0));
        send_word(event_word(KIND_COMMUTATE, 16'h0001, 1'b0));
        run_random(60, 10, 16'h0000, 16'h0000);

        repeat (3) @(posedge clk);
        if (fail_count == 0)
            $display("bldc_six_step_commutator: match");
        else
            $display("bldc_six_step_commutator: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bssc_pkg.sv
hw/rtl/bssc_regs.sv
hw/rtl/bssc_core.sv
hw/rtl/bldc_six_step_commutator.sv
dv/bldc_six_step_commutator_checker.sv
dv/bldc_six_step_commutator_tb.sv
